// ===== rtl/multichannel_exp_smoother_macros.svh =====
// assertion helpers shared by the rtl; clock clk_i and reset rst_ni are assumed in scope
`ifndef MULTICHANNEL_EXP_SMOOTHER_MACROS_SVH
`define MULTICHANNEL_EXP_SMOOTHER_MACROS_SVH

// general property, checked outside reset
`define MEXPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication, checked outside reset
`define MEXPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mexps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mexps_pkg;

  localparam int CHAN_W          = 4;
  localparam int COEF_W          = 16;
  localparam int FRAC_W          = 16;
  localparam int CHANNELS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  // one half in the q.16 fraction, used for round half up
  localparam int HALF_LSB        = 1 << (FRAC_W - 1);
  // one in unsigned q0.16, needs one bit beyond the coefficient
  localparam int ONE_Q16         = 1 << COEF_W;

endpackage

`default_nettype wire

// ===== rtl/mexps_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mexps_in_if #(
  parameter int SampleBits = mexps_pkg::SAMPLE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [SampleBits-1:0]    sample;
  logic [mexps_pkg::CHAN_W-1:0]    channel;

  modport source (output valid, sample, channel, input ready);
  modport sink   (input valid, sample, channel, output ready);
endinterface

`default_nettype wire

// ===== rtl/mexps_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mexps_out_if #(
  parameter int SampleBits = mexps_pkg::SAMPLE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [SampleBits-1:0]    smoothed_value;
  logic [mexps_pkg::CHAN_W-1:0]    out_channel;

  modport source (output valid, smoothed_value, out_channel, input ready);
  modport sink   (input valid, smoothed_value, out_channel, output ready);
endinterface

`default_nettype wire

// ===== rtl/multichannel_exp_smoother.sv =====
// multichannel exponential smoother: one single-pole low-pass per channel, all channels
// sharing the unsigned q0.16 coefficient written on cfg_we_i/cfg_wdata_i. each input beat
// (signed sample, channel) gives exactly one output beat: the channel's new level
// coef*level + (1-coef)*sample held in q.16, rounded half up to an integer, with its channel.
// the first sample on a channel after reset or after any coefficient write loads the level
// directly; a zero coefficient passes samples through; a channel at or above CHANNELS passes
// the sample through and leaves all state alone. throughput is one beat per clock, any channel
// order, including the same channel on consecutive beats, while out_o.ready holds; each beat
// is registered in stage 1 and then in the output register, from which the result leaves.
// the rate is set by the single multiply-accumulate stage, which reads the level from a
// synchronous ram and takes the last written level through a forwarding register when the
// previous beat hit the same channel. the coefficient may only be written while no beat is
// in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_exp_smoother_macros.svh"

module multichannel_exp_smoother #(
  parameter int CHANNELS    = mexps_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = mexps_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mexps_pkg::COEF_W-1:0] cfg_wdata_i,
  mexps_in_if.sink                          in_i,
  mexps_out_if.source                       out_o
);

  localparam int IdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FracW  = mexps_pkg::FRAC_W;
  localparam int CoefW  = mexps_pkg::COEF_W;
  localparam int LevelW = SAMPLE_BITS + FracW;        // q(sample).16 level
  localparam int ProdW  = SAMPLE_BITS + CoefW + 2;    // (1-coef)*sample, and the level sum
  localparam int MacW   = LevelW + CoefW + 1;         // coef*level

  localparam logic [8:0]          ChanLimit = 9'(CHANNELS);
  localparam logic [CoefW:0]      OneQ16    = (CoefW + 1)'(mexps_pkg::ONE_Q16);
  localparam logic signed [MacW-1:0]   MacHalf = MacW'(mexps_pkg::HALF_LSB);
  localparam logic signed [LevelW:0]   LvlHalf = (LevelW + 1)'(mexps_pkg::HALF_LSB);
  localparam logic signed [SAMPLE_BITS-1:0] SatMax = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SatMin = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // coefficient register and per-channel started flags
  logic [CoefW-1:0]    coef_q;
  logic [CHANNELS-1:0] started_q;

  // stage 1: level read in flight, (1-coef)*sample already formed
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [mexps_pkg::CHAN_W-1:0]  s1_chan_q;
  logic [IdxW-1:0]               s1_idx_q;
  logic                          s1_inrange_q;
  logic signed [ProdW-1:0]       s1_prod_q;

  // last level written, for a same-channel beat right behind it
  logic                          fwd_valid_q;
  logic [IdxW-1:0]               fwd_idx_q;
  logic signed [LevelW-1:0]      fwd_level_q;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [mexps_pkg::CHAN_W-1:0]  out_chan_q;

  logic                          in_accept;
  logic                          s1_adv;
  logic [IdxW-1:0]               in_idx;
  logic                          in_inrange;
  logic [CoefW:0]                one_minus_coef;
  logic signed [ProdW-1:0]       prod0;

  logic [LevelW-1:0]             ram_rdata;
  logic                          ram_we;
  logic signed [LevelW-1:0]      level_op;
  logic                          s1_started;
  logic signed [MacW-1:0]        mac;
  logic signed [MacW-1:0]        mac_rnd;
  logic signed [ProdW-1:0]       level_sum;
  logic signed [LevelW-1:0]      new_level;
  logic signed [LevelW:0]        lvl_rnd;
  logic signed [SAMPLE_BITS:0]   int_rnd;
  logic signed [SAMPLE_BITS-1:0] result;

  // handshake: stage 1 moves on whenever the output register is free or being emptied
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_accept  = in_i.valid && in_i.ready;

  assign in_idx     = IdxW'(in_i.channel);
  assign in_inrange = 9'(in_i.channel) < ChanLimit;

  // stage 0 multiplier: (1-coef)*sample, already scaled by 2^16
  assign one_minus_coef = OneQ16 - {1'b0, coef_q};
  assign prod0          = ProdW'($signed({1'b0, one_minus_coef})) * ProdW'(in_i.sample);

  mexps_ram #(
    .Width (LevelW),
    .Depth (CHANNELS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_idx_q),
    .wdata_i (new_level),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // the ram returns old data when the previous beat writes the same entry on the read edge
  assign level_op   = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_level_q
                                                                : $signed(ram_rdata);
  assign s1_started = s1_inrange_q && started_q[s1_idx_q];

  // coef*level rounded back to q.16; a zero coefficient reduces this to the plain sample
  assign mac       = MacW'($signed({1'b0, coef_q})) * MacW'(level_op);
  assign mac_rnd   = mac + MacHalf;
  assign level_sum = ProdW'(mac_rnd >>> FracW) + s1_prod_q;

  always_comb begin
    if (s1_started) begin
      new_level = LevelW'(level_sum);
    end else begin
      new_level = {s1_sample_q, {FracW{1'b0}}};
    end
  end

  // round half up to an integer and clamp to the sample range; an out-of-range channel passes its sample
  assign lvl_rnd = {new_level[LevelW-1], new_level} + LvlHalf;
  assign int_rnd = lvl_rnd[LevelW:FracW];

  always_comb begin
    if (!s1_inrange_q) begin
      result = s1_sample_q;
    end else if (int_rnd[SAMPLE_BITS] != int_rnd[SAMPLE_BITS-1]) begin
      result = int_rnd[SAMPLE_BITS] ? SatMin : SatMax;
    end else begin
      result = int_rnd[SAMPLE_BITS-1:0];
    end
  end

  assign ram_we = s1_adv && s1_inrange_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= '0;
      started_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        coef_q    <= cfg_wdata_i;
        started_q <= '0;
      end else if (ram_we) begin
        started_q[s1_idx_q] <= 1'b1;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (ram_we) begin
        fwd_valid_q <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q  <= in_i.sample;
      s1_chan_q    <= in_i.channel;
      s1_idx_q     <= in_idx;
      s1_inrange_q <= in_inrange;
      s1_prod_q    <= prod0;
    end
    if (ram_we) begin
      fwd_idx_q   <= s1_idx_q;
      fwd_level_q <= new_level;
    end
    if (s1_adv) begin
      out_value_q <= result;
      out_chan_q  <= s1_chan_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.smoothed_value = out_value_q;
  assign out_o.out_channel    = out_chan_q;

  // a coefficient write restarts every channel
  `MEXPS_ASSERT(a_cfg_clears_started, cfg_we_i |=> (started_q == '0), "started flags not cleared")
  // a level write marks its channel as started
  `MEXPS_ASSERT(a_write_sets_started, (ram_we && !cfg_we_i) |=> started_q[$past(s1_idx_q)],
                "channel not marked started after level write")
  // a held result blocks stage 1, so no beat may enter behind a full stage 1
  `MEXPS_ASSERT_IMPL(a_no_accept_when_full, s1_valid_q && out_valid_q && !out_o.ready,
                     !in_accept, "beat accepted while stage 1 is blocked")
  // a fresh output beat comes only from stage 1
  `MEXPS_ASSERT(a_out_from_stage1, $rose(out_valid_q) |-> $past(s1_valid_q),
                "output valid without a beat in stage 1")

endmodule

`default_nettype wire

// ===== rtl/mexps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexps_ram #(
  parameter int Width = 32,
  parameter int Depth = mexps_pkg::CHANNELS_DEF,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/mexps_checker.sv =====
`timescale 1ns / 1ps

module mexps_checker (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [mexps_pkg::COEF_W-1:0]               cfg_wdata_i,
  input  logic                                       in_valid_i,
  input  logic                                       in_ready_i,
  input  logic signed [mexps_pkg::SAMPLE_BITS_DEF-1:0] in_sample_i,
  input  logic [mexps_pkg::CHAN_W-1:0]               in_channel_i,
  input  logic                                       out_valid_i,
  input  logic                                       out_ready_i,
  input  logic signed [mexps_pkg::SAMPLE_BITS_DEF-1:0] out_value_i,
  input  logic [mexps_pkg::CHAN_W-1:0]               out_channel_i,
  output int                                         mismatches_o,
  output int                                         outstanding_o,
  output int                                         checked_o
);
  import mexps_pkg::*;

  localparam int CHANNELS     = CHANNELS_DEF;
  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int LEVEL_W      = SAMPLE_BITS + FRAC_W;
  localparam int REPORT_LIMIT = 10;
  localparam longint OUT_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN  = -(longint'(1) << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CHAN_W-1:0]             channel;
  } smoothed_t;

  logic [COEF_W-1:0]          coef_q;
  logic signed [LEVEL_W-1:0]  level_q [CHANNELS];
  logic                       started_q [CHANNELS];
  smoothed_t                  expected_levels_q [$];
  int                         mismatch_cnt;
  int                         checked_cnt;

  // updates the channel level in q.16 and returns the rounded, saturated result
  function automatic smoothed_t advance_channel(input logic signed [SAMPLE_BITS-1:0] sample,
                                                input logic [CHAN_W-1:0] ch);
    longint    c;
    longint    ip;
    longint    fr;
    longint    total;
    longint    rounded;
    smoothed_t res;
    res.channel = ch;
    if (ch >= CHANNELS) begin
      res.value = sample;
    end else begin
      if (!started_q[ch] || coef_q == '0) begin
        started_q[ch] = 1'b1;
        level_q[ch]   = {sample, {FRAC_W{1'b0}}};
      end else begin
        c     = longint'(coef_q);
        ip    = longint'($signed(level_q[ch][LEVEL_W-1:FRAC_W]));
        fr    = longint'(level_q[ch][FRAC_W-1:0]);
        total = c * ip + (ONE_Q16 - c) * longint'(sample) + ((c * fr + HALF_LSB) >>> FRAC_W);
        level_q[ch] = total[LEVEL_W-1:0];
      end
      ip      = longint'($signed(level_q[ch][LEVEL_W-1:FRAC_W]));
      rounded = ip + ((level_q[ch][FRAC_W-1:0] >= HALF_LSB) ? 1 : 0);
      if (rounded > OUT_MAX) rounded = OUT_MAX;
      if (rounded < OUT_MIN) rounded = OUT_MIN;
      res.value = rounded[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    smoothed_t want;
    if (!rst_ni) begin
      coef_q = '0;
      foreach (started_q[i]) begin
        started_q[i] = 1'b0;
        level_q[i]   = '0;
      end
      expected_levels_q.delete();
      mismatch_cnt  = 0;
      checked_cnt   = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      // result side first: a beat accepted now cannot come out at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_levels_q.size() == 0) begin
          if (mismatch_cnt < REPORT_LIMIT)
            $display("%0t: unexpected result value %0d channel %0d", $time, out_value_i,
                     out_channel_i);
          mismatch_cnt++;
        end else begin
          want = expected_levels_q.pop_front();
          checked_cnt++;
          if (want.value !== out_value_i || want.channel !== out_channel_i) begin
            if (mismatch_cnt < REPORT_LIMIT)
              $display("%0t: result mismatch: value exp %0d got %0d, channel exp %0d got %0d",
                       $time, want.value, out_value_i, want.channel, out_channel_i);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        coef_q = cfg_wdata_i;
        foreach (started_q[i]) started_q[i] = 1'b0;
      end
      if (in_valid_i && in_ready_i)
        expected_levels_q.push_back(advance_channel(in_sample_i, in_channel_i));
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= expected_levels_q.size();
      checked_o     <= checked_cnt;
    end
  end

endmodule

// ===== tb/tb_multichannel_exp_smoother.sv =====
`timescale 1ns / 1ps

module tb_multichannel_exp_smoother;
  import mexps_pkg::*;

  // run shape: directed opener, then random phases each under its own coefficient
  localparam int RAND_ITEMS  = 1430;
  localparam int PHASES      = 8;
  localparam int GAP_STRETCH = 40;      // beats between re-rolls of the idling switches
  localparam int LONG_HOLD   = 300;     // receiver hold-off, long enough to back up the pipe
  localparam int DRAIN       = 20;      // cycles after the last result
  localparam int LIMIT       = 400000;  // watchdog, far above the slowest legal run

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [COEF_W-1:0] cfg_wdata;

  mexps_in_if  in_bus ();
  mexps_out_if out_bus ();

  int  mismatches;
  int  outstanding;
  int  checked;
  int  cycle_cnt = 0;
  int  beats_sent = 0;
  int  coef_writes = 0;
  int  hold_off_requests = 0;
  int  hold_offs_done = 0;
  bit  send_gaps = 1'b0;
  bit  recv_gaps = 1'b0;
  logic [CHAN_W-1:0] last_ch = '0;

  multichannel_exp_smoother u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // predicts every beat and compares results in order
  mexps_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_bus.valid),
    .in_ready_i    (in_bus.ready),
    .in_sample_i   (in_bus.sample),
    .in_channel_i  (in_bus.channel),
    .out_valid_i   (out_bus.valid),
    .out_ready_i   (out_bus.ready),
    .out_value_i   (out_bus.smoothed_value),
    .out_channel_i (out_bus.out_channel),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("[multichannel_exp_smoother] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_offs_done != hold_off_requests) begin
        // sender keeps offering, so the block fills up and drops in_bus.ready
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_offs_done++;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one input beat, optionally after an idle burst; returns on the accepting edge
  task automatic send_beat(input logic signed [SAMPLE_BITS_DEF-1:0] s,
                           input logic [CHAN_W-1:0] ch);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.sample  <= s;
    in_bus.channel <= ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    beats_sent++;
    last_ch = ch;
  endtask

  // stop offering and wait until every expected result has come out
  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // coefficient is only written with nothing in flight
  task automatic write_coef(input logic [COEF_W-1:0] value);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    coef_writes++;
  endtask

  // mostly full-range samples, with the rails and values near zero favoured
  function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample();
    logic signed [SAMPLE_BITS_DEF-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = 16'sh7fff;
      1:       s = 16'sh8000;
      2:       s = SAMPLE_BITS_DEF'(int'($urandom_range(0, 15)) - 8);
      default: s = SAMPLE_BITS_DEF'($urandom);
    endcase
    return s;
  endfunction

  // repeats the last channel often, to hit back-to-back updates of one level
  function automatic logic [CHAN_W-1:0] pick_channel();
    logic [CHAN_W-1:0] ch;
    case ($urandom_range(0, 3))
      0:       ch = last_ch;
      1:       ch = CHAN_W'($urandom_range(0, 3));
      default: ch = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
    endcase
    return ch;
  endfunction

  function automatic logic [COEF_W-1:0] phase_coef(input int p);
    logic [COEF_W-1:0] c;
    case (p)
      0:       c = 16'hffff;    // heaviest smoothing
      1:       c = 16'h0000;    // pass-through
      2:       c = 16'h0001;    // almost no smoothing
      3:       c = 16'h8000;    // half weight, rounding ties show up
      default: c = COEF_W'($urandom);
    endcase
    return c;
  endfunction

  initial begin
    int per_phase;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.channel = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coefficient still at its reset value of zero
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    send_beat(16'sh7fff, 4'd0);     // first beat loads the level
    send_beat(16'sh8000, 4'd0);     // zero coefficient on a started channel passes through
    send_beat(-16'sd1,   4'd15);
    send_beat(16'sd0,    4'd15);
    send_beat(16'sd1,    4'd7);

    // heaviest smoothing, full swing between the rails
    write_coef(16'hffff);
    send_beat(16'sh8000, 4'd0);
    send_beat(16'sh7fff, 4'd0);
    send_beat(16'sh7fff, 4'd0);
    send_beat(16'sh7fff, 4'd0);

    // half weight: exact halves round upwards, both signs
    write_coef(16'h8000);
    send_beat(16'sd0,    4'd1);
    send_beat(16'sd1,    4'd1);
    send_beat(16'sd0,    4'd2);
    send_beat(-16'sd1,   4'd2);
    send_beat(16'sh7fff, 4'd3);
    send_beat(16'sh7fff, 4'd3);
    send_beat(16'sh8000, 4'd3);

    // rewriting the same value still restarts every channel
    write_coef(16'h8000);
    send_beat(16'sd100,  4'd1);

    write_coef(16'h0001);
    send_beat(16'sh8000, 4'd4);
    send_beat(16'sh7fff, 4'd4);

    write_coef(16'h0000);
    send_beat(16'sd5,    4'd5);
    send_beat(-16'sd5,   4'd5);

    // random phases, one coefficient each; the last one runs without idling
    per_phase = RAND_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      write_coef(phase_coef(p));
      if (p == 2) hold_off_requests++;
      for (int n = 0; n < per_phase; n++) begin
        if (n % GAP_STRETCH == 0) begin
          send_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
          recv_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        send_beat(pick_sample(), pick_channel());
      end
    end

    // wind down: everything out, then a further DRAIN wait for stray beats
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d sample beats across %0d coefficient writes, including a long",
             beats_sent, coef_writes);
    $display("receiver hold-off; %0d results compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[multichannel_exp_smoother] OK");
    end else begin
      $display("[multichannel_exp_smoother] ERROR");
    end
    $finish;
  end

endmodule
